// File: hw/rtl/pds_pkg.sv
// Shared types and constants for the PLL divider search block.
`timescale 1ns / 1ps
package pds_pkg;

  localparam int TARGET_W   = 31;
  localparam int OSC_W      = 26;
  localparam int ERR_W      = 32;
  localparam int MULT_FW    = 7;
  localparam int PREDIV_FW  = 2;
  localparam int DIV_FW     = 7;
  localparam int DCLK_FW    = 8;

  localparam logic [OSC_W-1:0]     OSC_RESET       = 26'd24000000;
  localparam logic [ERR_W-1:0]     ERR_MAX         = 32'hffff_ffff;
  localparam logic [MULT_FW-1:0]   BEST_MULT_RST   = 7'd12;
  localparam logic [PREDIV_FW-1:0] BEST_PREDIV_RST = 2'd1;
  localparam logic [DIV_FW-1:0]    BEST_DIV_RST    = 7'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVM_S,
    ST_DIVM_W,
    ST_DIVD_S,
    ST_DIVD_W,
    ST_CMP,
    ST_DONE
  } pds_state_t;

  // Status of the shared divider toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pds_div_stat_t;

  // Control of the running-best tracker.
  typedef struct packed {
    logic clear;
    logic cmp;
  } pds_trk_ctrl_t;

endpackage

// File: hw/rtl/pds_if.sv
// Handshake channel interfaces for the request and the result.
`timescale 1ns / 1ps
interface pds_in_if import pds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink (input valid, input target_hz, output ready);
endinterface

interface pds_out_if import pds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MULT_FW-1:0]   best_mult;
  logic [PREDIV_FW-1:0] best_prediv;
  logic [DIV_FW-1:0]    best_div;
  logic [ERR_W-1:0]     best_error;
  logic [DCLK_FW-1:0]   dclk_field;
  logic                 exact_hit;

  modport source (output valid, output best_mult, output best_prediv, output best_div,
                  output best_error, output dclk_field, output exact_hit, input ready);
  modport sink (input valid, input best_mult, input best_prediv, input best_div,
                input best_error, input dclk_field, input exact_hit, output ready);
endinterface

// File: hw/rtl/pds_divider.sv
// Bit-serial restoring divider shared by the pre-divider and dot-clock steps.
`timescale 1ns / 1ps
module pds_divider import pds_pkg::*; #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output pds_div_stat_t    stat,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    take    = (trial >= {1'b0, den_r});
    rem_nxt = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// File: hw/rtl/pds_best.sv
// Error calculation and running-best register for the candidate search.
`timescale 1ns / 1ps
module pds_best import pds_pkg::*; #(
  parameter int FREQ_W = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pds_trk_ctrl_t        ctrl,
  input  logic [FREQ_W-1:0]    freq,
  input  logic [ERR_W-1:0]     target2,
  input  logic [MULT_FW-1:0]   cand_mult,
  input  logic [PREDIV_FW-1:0] cand_prediv,
  input  logic [DIV_FW-1:0]    cand_div,
  output logic                 cand_zero,
  output logic [MULT_FW-1:0]   best_mult,
  output logic [PREDIV_FW-1:0] best_prediv,
  output logic [DIV_FW-1:0]    best_div,
  output logic [ERR_W-1:0]     lead_err,
  output logic                 hit
);

  localparam int DW = ((FREQ_W > ERR_W) ? FREQ_W : ERR_W) + 1;

  logic [DW-1:0]        fe, te, diff;
  logic [ERR_W-1:0]     err;
  logic                 better;
  logic [MULT_FW-1:0]   mult_r;
  logic [PREDIV_FW-1:0] prediv_r;
  logic [DIV_FW-1:0]    div_r;
  logic [ERR_W-1:0]     err_r;
  logic                 hit_r;

  always_comb begin
    fe     = DW'(freq);
    te     = DW'(target2);
    diff   = (fe > te) ? (fe - te) : (te - fe);
    // An error that does not fit in 32 bits saturates.
    err    = (|diff[DW-1:ERR_W]) ? ERR_MAX : diff[ERR_W-1:0];
    better = (err < err_r);
  end

  assign cand_zero = (err == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.clear) begin
      hit_r <= 1'b0;
    end else if (ctrl.cmp && better && cand_zero) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      err_r    <= ERR_MAX;
      mult_r   <= BEST_MULT_RST;
      prediv_r <= BEST_PREDIV_RST;
      div_r    <= BEST_DIV_RST;
    end else if (ctrl.cmp && better) begin
      err_r    <= err;
      mult_r   <= cand_mult;
      prediv_r <= cand_prediv;
      div_r    <= cand_div;
    end
  end

  assign best_mult   = mult_r;
  assign best_prediv = prediv_r;
  assign best_div    = div_r;
  assign lead_err    = err_r;
  assign hit         = hit_r;

endmodule

// File: hw/rtl/pll_divider_search_core.sv
// Top level of the PLL multiplier, pre-divider and dot-clock divider search.
`timescale 1ns / 1ps
// A request carries a target pixel clock in hertz, which is doubled and then
// matched against every candidate floor(floor(osc_hz*n/m)/d), with n outermost
// and d innermost. The first candidate with the smallest absolute error wins,
// and the search ends early on an exact match. All divisions run through one
// bit-serial divider that needs one cycle per quotient bit (26 plus the
// multiplier width, 33 bits by default); each d needs one dot-clock divide,
// and each new n or m needs a pre-divide first. An exact hit ends a search
// before the full walk. The block takes no request while a search runs, but a
// new one may start while the previous result still waits on the output.
// osc_hz may be written only while the block is idle.
module pll_divider_search_core import pds_pkg::*; #(
  parameter int MULT_MIN     = 12,
  parameter int MULT_LIMIT   = 100,
  parameter int PREDIV_LIMIT = 3,
  parameter int DIV_MIN      = 6,
  parameter int DIV_LIMIT    = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [OSC_W-1:0] cfg_wdata,
  pds_in_if.sink           in_if,
  pds_out_if.source        out_if
);

  localparam int MULT_W   = $clog2(MULT_LIMIT);
  localparam int PREDIV_W = $clog2(PREDIV_LIMIT);
  localparam int DIV_W    = $clog2(DIV_LIMIT);
  localparam int DEN_W    = (DIV_W > PREDIV_W) ? DIV_W : PREDIV_W;
  localparam int PROD_W   = OSC_W + MULT_W;
  localparam bit EMPTY    = (MULT_MIN >= MULT_LIMIT) || (DIV_MIN >= DIV_LIMIT);

  pds_state_t state_r, state_nxt;

  logic [OSC_W-1:0]    osc_r;
  logic [ERR_W-1:0]    target2_r;
  logic [MULT_W-1:0]   n_r;
  logic [PREDIV_W-1:0] m_r;
  logic [DIV_W-1:0]    d_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   vco_r;

  logic                in_xfer;
  logic                n_last, m_last, d_last;
  logic                out_free;

  logic                div_start;
  logic                div_sel_d;
  logic [PROD_W-1:0]   div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  pds_div_stat_t       div_stat;
  logic [PROD_W-1:0]   div_quot;

  pds_trk_ctrl_t        trk_ctrl;
  logic                 cand_zero;
  logic [MULT_FW-1:0]   best_mult;
  logic [PREDIV_FW-1:0] best_prediv;
  logic [DIV_FW-1:0]    best_div;
  logic [ERR_W-1:0]     lead_err;
  logic                 best_hit;

  logic                 out_valid_r;
  logic [MULT_FW-1:0]   out_mult_r;
  logic [PREDIV_FW-1:0] out_prediv_r;
  logic [DIV_FW-1:0]    out_div_r;
  logic [ERR_W-1:0]     out_err_r;
  logic                 out_hit_r;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign n_last      = (n_r == MULT_W'(MULT_LIMIT - 1));
  assign m_last      = (m_r == PREDIV_W'(PREDIV_LIMIT - 1));
  assign d_last      = (d_r == DIV_W'(DIV_LIMIT - 1));
  assign out_free    = !out_valid_r || out_if.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = EMPTY ? ST_DONE : ST_MUL;
      end
      ST_MUL:    state_nxt = ST_DIVM_S;
      ST_DIVM_S: state_nxt = ST_DIVM_W;
      ST_DIVM_W: begin
        if (div_stat.done) state_nxt = ST_DIVD_S;
      end
      ST_DIVD_S: state_nxt = ST_DIVD_W;
      ST_DIVD_W: begin
        if (div_stat.done) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        priority if (cand_zero) state_nxt = ST_DONE;
        else if (!d_last)       state_nxt = ST_DIVD_S;
        else if (!m_last)       state_nxt = ST_DIVM_S;
        else if (!n_last)       state_nxt = ST_MUL;
        else                    state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    div_start      = 1'b0;
    div_sel_d      = 1'b0;
    trk_ctrl.clear = 1'b0;
    trk_ctrl.cmp   = 1'b0;
    unique case (state_r)
      ST_IDLE:   trk_ctrl.clear = in_xfer;
      ST_DIVM_S: div_start = 1'b1;
      ST_DIVD_S: begin
        div_start = 1'b1;
        div_sel_d = 1'b1;
      end
      ST_CMP:    trk_ctrl.cmp = 1'b1;
      default: begin
      end
    endcase
  end

  assign div_dividend = div_sel_d ? vco_r : prod_r;
  assign div_divisor  = div_sel_d ? DEN_W'(d_r) : DEN_W'(m_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      osc_r   <= OSC_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) osc_r <= cfg_wdata;
    end
  end

  // Loop counters and datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      target2_r <= {in_if.target_hz, 1'b0};
      n_r       <= MULT_W'(MULT_MIN);
      m_r       <= PREDIV_W'(1);
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(osc_r) * PROD_W'(n_r);
    end
    if (state_r == ST_DIVM_W && div_stat.done) begin
      vco_r <= div_quot;
      d_r   <= DIV_W'(DIV_MIN);
    end
    if (state_r == ST_CMP && !cand_zero) begin
      if (!d_last) begin
        d_r <= d_r + 1'b1;
      end else if (!m_last) begin
        m_r <= m_r + 1'b1;
      end else if (!n_last) begin
        n_r <= n_r + 1'b1;
        m_r <= PREDIV_W'(1);
      end
    end
  end

  pds_divider #(
    .NUM_W (PROD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  pds_best #(
    .FREQ_W (PROD_W)
  ) u_best (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (trk_ctrl),
    .freq        (div_quot),
    .target2     (target2_r),
    .cand_mult   (MULT_FW'(n_r)),
    .cand_prediv (PREDIV_FW'(m_r)),
    .cand_div    (DIV_FW'(d_r)),
    .cand_zero   (cand_zero),
    .best_mult   (best_mult),
    .best_prediv (best_prediv),
    .best_div    (best_div),
    .lead_err    (lead_err),
    .hit         (best_hit)
  );

  // Result register: holds one finished result while the next search runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_mult_r   <= best_mult;
      out_prediv_r <= best_prediv;
      out_div_r    <= best_div;
      out_err_r    <= lead_err;
      out_hit_r    <= best_hit;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.best_mult   = out_mult_r;
  assign out_if.best_prediv = out_prediv_r;
  assign out_if.best_div    = out_div_r;
  assign out_if.best_error  = out_err_r;
  assign out_if.dclk_field  = {out_div_r, 1'b0};
  assign out_if.exact_hit   = out_hit_r;

endmodule

// File: sim/pds_search_checker.sv
// Checker that predicts every divider search result and compares it with the block output.
`timescale 1ns / 1ps
module pds_search_checker import pds_pkg::*; #(
  parameter int MULT_MIN     = 12,
  parameter int MULT_LIMIT   = 100,
  parameter int PREDIV_LIMIT = 3,
  parameter int DIV_MIN      = 6,
  parameter int DIV_LIMIT    = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [OSC_W-1:0] cfg_wdata,
  pds_in_if                in_ch,
  pds_out_if               out_ch,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [MULT_FW-1:0]   mult;
    logic [PREDIV_FW-1:0] prediv;
    logic [DIV_FW-1:0]    div;
    logic [ERR_W-1:0]     err;
    logic [DCLK_FW-1:0]   dclk;
    logic                 hit;
  } pll_choice_t;

  pll_choice_t      choice_q[$];
  logic [OSC_W-1:0] osc_hz;
  int               fails = 0;

  assign fail_count = fails;

  // Walks n, then m, then d and keeps the first candidate with a strictly smaller
  // error. The running best restarts for every request and the walk stops on zero error.
  function automatic pll_choice_t search_best(input logic [TARGET_W-1:0] tgt,
                                              input logic [OSC_W-1:0] osc);
    pll_choice_t      res;
    longint unsigned  want;
    longint unsigned  osc64;
    longint unsigned  vco;
    longint unsigned  freq;
    longint unsigned  diff;
    logic [ERR_W-1:0] err;
    logic [ERR_W-1:0] low_err;
    int               best_n;
    int               best_m;
    int               best_d;
    bit               hit;
    want     = 64'(tgt) * 2;
    osc64    = 64'(osc);
    low_err  = ERR_MAX;
    best_n   = int'(BEST_MULT_RST);
    best_m   = int'(BEST_PREDIV_RST);
    best_d   = int'(BEST_DIV_RST);
    hit      = 1'b0;
    for (int n = MULT_MIN; n < MULT_LIMIT && !hit; n++) begin
      for (int m = 1; m < PREDIV_LIMIT && !hit; m++) begin
        vco = (osc64 * n) / m;
        for (int d = DIV_MIN; d < DIV_LIMIT && !hit; d++) begin
          freq = vco / d;
          diff = (freq > want) ? freq - want : want - freq;
          err  = (diff > ERR_MAX) ? ERR_MAX : diff[ERR_W-1:0];
          if (err < low_err) begin
            low_err = err;
            best_n  = n;
            best_m  = m;
            best_d  = d;
            if (err == '0) hit = 1'b1;
          end
        end
      end
    end
    res.mult   = best_n[MULT_FW-1:0];
    res.prediv = best_m[PREDIV_FW-1:0];
    res.div    = best_d[DIV_FW-1:0];
    res.err    = low_err;
    res.dclk   = 8'(best_d * 2);
    res.hit    = hit;
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    pll_choice_t want;
    if (!rst_n) begin
      osc_hz <= OSC_RESET;
      choice_q.delete();
    end else begin
      if (cfg_we) osc_hz <= cfg_wdata;
      // A result can never belong to a request accepted in the same cycle.
      if (out_ch.valid && out_ch.ready) begin
        if (choice_q.size() == 0) begin
          $error("Result transfer with no request outstanding");
          fails++;
        end else begin
          want = choice_q.pop_front();
          check_field("best_mult", 64'(want.mult), 64'(out_ch.best_mult));
          check_field("best_prediv", 64'(want.prediv), 64'(out_ch.best_prediv));
          check_field("best_div", 64'(want.div), 64'(out_ch.best_div));
          check_field("best_error", 64'(want.err), 64'(out_ch.best_error));
          check_field("dclk_field", 64'(want.dclk), 64'(out_ch.dclk_field));
          check_field("exact_hit", 64'(want.hit), 64'(out_ch.exact_hit));
        end
      end
      if (in_ch.valid && in_ch.ready) choice_q.push_back(search_best(in_ch.target_hz, osc_hz));
    end
    pending <= choice_q.size();
  end

endmodule

// File: sim/tb_pll_divider_search_core.sv
// Testbench top for the PLL divider search block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_pll_divider_search_core import pds_pkg::*; ();

  localparam int MULT_MIN     = 12;
  localparam int MULT_LIMIT   = 100;
  localparam int PREDIV_LIMIT = 3;
  localparam int DIV_MIN      = 6;
  localparam int DIV_LIMIT    = 128;
  localparam int LONG_HOLD    = 60000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [OSC_W-1:0] cfg_wdata;
  logic [OSC_W-1:0] osc_now;
  int               fail_count;
  int               pending;
  int               n_sent;
  int               n_osc;
  bit               gaps_on;
  bit               hold_out;
  bit               hold_done;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pll_divider_search_core #(
    .MULT_MIN    (MULT_MIN),
    .MULT_LIMIT  (MULT_LIMIT),
    .PREDIV_LIMIT(PREDIV_LIMIT),
    .DIV_MIN     (DIV_MIN),
    .DIV_LIMIT   (DIV_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  pds_search_checker #(
    .MULT_MIN    (MULT_MIN),
    .MULT_LIMIT  (MULT_LIMIT),
    .PREDIV_LIMIT(PREDIV_LIMIT),
    .DIV_MIN     (DIV_MIN),
    .DIV_LIMIT   (DIV_LIMIT)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Covers a run in which every request needs a full search, with margin.
  initial begin
    #(64'd4_000_000_000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Picks a reachable candidate early in the search so that the block stops on an
  // exact hit instead of walking all multipliers. Odd frequencies cannot be hit.
  function automatic logic [TARGET_W-1:0] hit_target(input int n_span);
    longint unsigned freq;
    longint unsigned osc64;
    int              n;
    int              m;
    int              d;
    osc64 = 64'(osc_now);
    freq  = 1;
    for (int tries = 0; tries < 32 && freq[0]; tries++) begin
      n    = MULT_MIN + $urandom_range(0, n_span);
      m    = $urandom_range(1, PREDIV_LIMIT - 1);
      d    = $urandom_range(DIV_MIN, DIV_LIMIT - 1);
      freq = ((osc64 * n) / m) / d;
    end
    return TARGET_W'(freq >> 1);
  endfunction

  task automatic send_target(input logic [TARGET_W-1:0] tgt);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.target_hz <= tgt;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_osc(input logic [OSC_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we  <= 1'b0;
    osc_now = val;
    n_osc++;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int noise_left;
    in_ch.valid     <= 1'b0;
    in_ch.target_hz <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    gaps_on    = 1'b1;
    hold_out   = 1'b0;
    osc_now    = OSC_RESET;
    n_sent     = 0;
    n_osc      = 1;
    noise_left = 2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Oscillator at its reset value: exact hit on the first candidate, then the
    // largest target, which needs the full search and ends on the top multiplier.
    send_target(TARGET_W'(24_000_000));
    send_target('1);
    send_target(hit_target(1));
    send_target(hit_target(1));

    // With no oscillator every candidate is zero and the error is the doubled target.
    set_osc('0);
    send_target('0);
    send_target(TARGET_W'(1000));

    // Tiny oscillator: many candidates collapse to zero or one.
    set_osc(OSC_W'(1));
    send_target('0);
    send_target(TARGET_W'(1));
    send_target(TARGET_W'(2));

    set_osc('1);
    send_target(TARGET_W'(67_108_863));
    send_target(hit_target(1));
    send_target(hit_target(1));

    set_osc(OSC_W'(43_000_000));
    send_target(TARGET_W'(43_000_000));
    send_target(hit_target(1));
    send_target(hit_target(1));

    for (int ph = 0; ph < 6; ph++) begin
      if ($urandom_range(0, 4) == 0) set_osc(OSC_W'($urandom()));
      else set_osc(OSC_W'($urandom_range(1, 43_000_000)));
      gaps_on = (ph != 2);
      // Results stay blocked while requests keep coming, so the block backs up.
      if (ph == 3) begin
        hold_out = 1'b1;
        repeat (3) send_target(hit_target(0));
      end
      for (int k = 0; k < 13; k++) begin
        if (noise_left > 0 && $urandom_range(0, 39) == 0) begin
          noise_left--;
          send_target(TARGET_W'($urandom()));
        end else begin
          send_target(hit_target(($urandom_range(0, 9) == 0) ? 8 : 1));
        end
      end
    end

    drain();
    repeat (2000) @(posedge clk);
    $display("Covered %0d search requests over %0d oscillator settings,", n_sent, n_osc);
    $display("with exact hits, full searches, a zero oscillator and a long result stall.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
